>>> rtl/core/nsms_pkg.sv
// ----------------------------------------------------------------------------
// nsms_pkg
// Shared widths, constants and types of the string match statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package nsms_pkg;

  localparam int unsigned PATTERN_MAX_DEF = 16;
  localparam int unsigned TEXT_MAX_DEF    = 65536;

  localparam int BYTE_W        = 8;
  localparam int LEN_W         = 5;
  localparam int POS_W         = 16;
  localparam int COUNT_W       = 16;
  localparam int CMP_W         = 21;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 2;
  localparam int WORD_BYTES    = CFG_W / BYTE_W;
  localparam int PATTERN_BYTES = 2 * WORD_BYTES;

  localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};
  localparam logic [CMP_W-1:0]   CMP_SAT   = {CMP_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [PATTERN_BYTES-1:0][BYTE_W-1:0] pattern;
    logic [LEN_W-1:0]                     length;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              last_byte;
  } item_t;

endpackage

`default_nettype wire

>>> rtl/core/nsms_text_if.sv
// ----------------------------------------------------------------------------
// nsms_text_if
// Text channel: one text byte and its end-of-text mark per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface nsms_text_if;
  logic                      valid;
  logic                      ready;
  logic [nsms_pkg::BYTE_W-1:0] text_byte;
  logic                      last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/core/nsms_result_if.sv
// ----------------------------------------------------------------------------
// nsms_result_if
// Result channel: the statistics report of one text.
// ----------------------------------------------------------------------------
`default_nettype none

interface nsms_result_if;
  logic                         valid;
  logic                         ready;
  logic                         first_found;
  logic [nsms_pkg::POS_W-1:0]   first_position;
  logic                         last_found;
  logic [nsms_pkg::POS_W-1:0]   last_position;
  logic [nsms_pkg::COUNT_W-1:0] match_count;
  logic [nsms_pkg::LEN_W-1:0]   longest_prefix;
  logic [nsms_pkg::CMP_W-1:0]   comparisons;
  logic                         text_overflow;

  modport source (
    output valid, output first_found, output first_position, output last_found,
    output last_position, output match_count, output longest_prefix,
    output comparisons, output text_overflow, input ready
  );
  modport sink (
    input valid, input first_found, input first_position, input last_found,
    input last_position, input match_count, input longest_prefix,
    input comparisons, input text_overflow, output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/nsms_cfg_regs.sv
// ----------------------------------------------------------------------------
// nsms_cfg_regs
// Pattern and length registers; presents the clamped pattern length.
// ----------------------------------------------------------------------------
`default_nettype none

module nsms_cfg_regs #(
  parameter int unsigned PATTERN_MAX = nsms_pkg::PATTERN_MAX_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [nsms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [nsms_pkg::CFG_W-1:0]     cfg_data,
  output nsms_pkg::cfg_t                      cfg
);

  logic [nsms_pkg::CFG_W-1:0] pattern_low;
  logic [nsms_pkg::CFG_W-1:0] pattern_high;
  logic [nsms_pkg::LEN_W-1:0] pattern_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= nsms_pkg::LEN_W'(1);
    end else if (cfg_write) begin
      unique case (nsms_pkg::cfg_reg_t'(cfg_index))
        nsms_pkg::REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        nsms_pkg::REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        nsms_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[nsms_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.pattern = {pattern_high, pattern_low};
    if (pattern_length == '0) begin
      cfg.length = nsms_pkg::LEN_W'(1);
    end else if (pattern_length > nsms_pkg::LEN_W'(PATTERN_MAX)) begin
      cfg.length = nsms_pkg::LEN_W'(PATTERN_MAX);
    end else begin
      cfg.length = pattern_length;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/nsms_match.sv
// ----------------------------------------------------------------------------
// nsms_match
// Compares the window's newest pattern-length bytes with the pattern and
// gives the length of the leading run of equal bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module nsms_match #(
  parameter int unsigned PATTERN_MAX = nsms_pkg::PATTERN_MAX_DEF
) (
  input  wire logic [PATTERN_MAX-1:0][nsms_pkg::BYTE_W-1:0]            win,
  input  wire logic [nsms_pkg::PATTERN_BYTES-1:0][nsms_pkg::BYTE_W-1:0] pattern,
  input  wire logic [nsms_pkg::LEN_W-1:0]                               n,
  output logic      [nsms_pkg::LEN_W-1:0]                               run
);

  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [PATTERN_MAX-1:0] eq;
  logic                   done;
  logic [IDX_W-1:0]       pos;

  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      pos   = IDX_W'(PATTERN_MAX - int'(n) + k);
      eq[k] = (win[pos] == pattern[k]);
    end
  end

  always_comb begin
    run  = n;
    done = 1'b0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (!done && ((nsms_pkg::LEN_W'(k) >= n) || !eq[k])) begin
        run  = nsms_pkg::LEN_W'(k);
        done = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/nsms_stats.sv
// ----------------------------------------------------------------------------
// nsms_stats
// Window, running statistics and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nsms_stats #(
  parameter int unsigned PATTERN_MAX = nsms_pkg::PATTERN_MAX_DEF,
  parameter int unsigned TEXT_MAX    = nsms_pkg::TEXT_MAX_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire nsms_pkg::item_t item,
  input  wire nsms_pkg::cfg_t  cfg,
  output logic                 take_ok,
  nsms_result_if.source        result
);

  localparam int BS_W = $clog2(TEXT_MAX + 1);

  logic [PATTERN_MAX-1:0][nsms_pkg::BYTE_W-1:0] window;
  logic [PATTERN_MAX-1:0][nsms_pkg::BYTE_W-1:0] win_shift;
  logic [BS_W-1:0]              bytes_seen, bytes_seen_next, seen_inc;
  logic                         any_match, any_match_next;
  logic [nsms_pkg::POS_W-1:0]   earliest_start, earliest_start_next;
  logic [nsms_pkg::POS_W-1:0]   latest_start, latest_start_next;
  logic [nsms_pkg::COUNT_W-1:0] full_match_total, full_match_total_next;
  logic [nsms_pkg::LEN_W-1:0]   best_prefix, best_prefix_next;
  logic [nsms_pkg::CMP_W-1:0]   compare_total, compare_total_next;
  logic                         overflowed, overflowed_next;
  logic [nsms_pkg::LEN_W-1:0]   run, cmp;
  logic [nsms_pkg::CMP_W:0]     cmp_sum;
  logic [BS_W-1:0]              start_full;
  logic                         ovf_hit, check;
  logic [nsms_pkg::CMP_W-1:0]   report_cmp;

  always_comb begin
    for (int i = 0; i < PATTERN_MAX - 1; i++) begin
      win_shift[i] = window[i + 1];
    end
    win_shift[PATTERN_MAX-1] = item.text_byte;
  end

  nsms_match #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_match (
    .win    (win_shift),
    .pattern(cfg.pattern),
    .n      (cfg.length),
    .run    (run)
  );

  always_comb begin
    ovf_hit    = (bytes_seen >= BS_W'(TEXT_MAX));
    seen_inc   = BS_W'(bytes_seen + 1'b1);
    check      = !ovf_hit && (seen_inc >= BS_W'(cfg.length));
    start_full = BS_W'(seen_inc - BS_W'(cfg.length));
    cmp        = (run < cfg.length) ? nsms_pkg::LEN_W'(run + 1'b1) : cfg.length;
    cmp_sum    = {1'b0, compare_total} + (nsms_pkg::CMP_W + 1)'(cmp);

    bytes_seen_next       = bytes_seen;
    any_match_next        = any_match;
    earliest_start_next   = earliest_start;
    latest_start_next     = latest_start;
    full_match_total_next = full_match_total;
    best_prefix_next      = best_prefix;
    compare_total_next    = compare_total;
    overflowed_next       = overflowed;

    if (ovf_hit) begin
      overflowed_next = 1'b1;
    end else begin
      bytes_seen_next = seen_inc;
    end

    if (check) begin
      compare_total_next = (cmp_sum > {1'b0, nsms_pkg::CMP_SAT}) ?
                           nsms_pkg::CMP_SAT : cmp_sum[nsms_pkg::CMP_W-1:0];
      if (run > best_prefix) begin
        best_prefix_next = run;
      end
      if (run == cfg.length) begin
        if (!any_match) begin
          earliest_start_next = nsms_pkg::POS_W'(start_full);
        end
        any_match_next    = 1'b1;
        latest_start_next = nsms_pkg::POS_W'(start_full);
        if (full_match_total != nsms_pkg::COUNT_SAT) begin
          full_match_total_next = full_match_total + 1'b1;
        end
      end
    end

    report_cmp = (compare_total_next == nsms_pkg::CMP_SAT) ?
                 nsms_pkg::CMP_SAT : compare_total_next + 1'b1;
  end

  assign take_ok = !result.valid || result.ready;

  // window holds only bytes of the current text wherever a start is checked
  always_ff @(posedge clk) begin
    if (step && !ovf_hit) begin
      window <= win_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen       <= '0;
      any_match        <= 1'b0;
      earliest_start   <= '0;
      latest_start     <= '0;
      full_match_total <= '0;
      best_prefix      <= '0;
      compare_total    <= '0;
      overflowed       <= 1'b0;
    end else if (step) begin
      if (item.last_byte) begin
        bytes_seen       <= '0;
        any_match        <= 1'b0;
        earliest_start   <= '0;
        latest_start     <= '0;
        full_match_total <= '0;
        best_prefix      <= '0;
        compare_total    <= '0;
        overflowed       <= 1'b0;
      end else begin
        bytes_seen       <= bytes_seen_next;
        any_match        <= any_match_next;
        earliest_start   <= earliest_start_next;
        latest_start     <= latest_start_next;
        full_match_total <= full_match_total_next;
        best_prefix      <= best_prefix_next;
        compare_total    <= compare_total_next;
        overflowed       <= overflowed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (step && item.last_byte) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && item.last_byte) begin
      result.first_found    <= any_match_next;
      result.first_position <= any_match_next ? earliest_start_next : '0;
      result.last_found     <= any_match_next;
      result.last_position  <= any_match_next ? latest_start_next : '0;
      result.match_count    <= full_match_total_next;
      result.longest_prefix <= best_prefix_next;
      result.comparisons    <= report_cmp;
      result.text_overflow  <= overflowed_next;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step && item.last_byte |=> bytes_seen == '0 && !any_match && compare_total == '0)
    else $error("stream state not cleared after last item");

  a_count_needs_match: assert property (@(posedge clk) disable iff (rst)
    !any_match |-> full_match_total == '0 && earliest_start == '0)
    else $error("match count without a match");

  a_prefix_bound: assert property (@(posedge clk) disable iff (rst)
    best_prefix <= nsms_pkg::LEN_W'(PATTERN_MAX))
    else $error("prefix beyond pattern size");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> bytes_seen == BS_W'(TEXT_MAX))
    else $error("overflow before text limit");

  a_report_found: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.match_count != '0) == result.first_found)
    else $error("found flag disagrees with match count");

endmodule

`default_nettype wire

>>> rtl/core/naive_string_match_stats.sv
// ----------------------------------------------------------------------------
// naive_string_match_stats
// Streaming naive string matcher with per-text statistics report.
// ----------------------------------------------------------------------------
// Text bytes enter on the text channel (valid/ready), one byte per item; the
// item with last_byte set closes the text. For each byte the block checks the
// start position that becomes complete and updates match positions, count,
// longest prefix and comparison total. On the closing byte it places one
// report on the result channel and clears its stream state.
// The pattern (two 64-bit byte words) and its length are to be written through
// cfg_write / cfg_index / cfg_data only while no text is in flight; the block
// itself does not enforce this. A report is registered from the closing item
// held in the input register, once the result register is free.
// Throughput: one item per cycle unless a closing byte waits on a held report;
// the window compare and statistics update before the result are combinational.
// Reset (rst, synchronous) empties both registers, clears the statistics and
// sets the pattern to zero with length one.
// A stalled receiver holds the report; ordinary bytes keep flowing, and the
// next closing byte waits in the input register until the report is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module naive_string_match_stats #(
  parameter int unsigned PATTERN_MAX = nsms_pkg::PATTERN_MAX_DEF,
  parameter int unsigned TEXT_MAX    = nsms_pkg::TEXT_MAX_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  nsms_text_if.sink                           text,
  nsms_result_if.source                       result,
  input  wire logic                           cfg_write,
  input  wire logic [nsms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [nsms_pkg::CFG_W-1:0]     cfg_data
);

  nsms_pkg::cfg_t  cfg;
  nsms_pkg::item_t item;
  logic            item_valid;
  logic            take_ok;
  logic            step;

  nsms_cfg_regs #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  assign step       = item_valid && (!item.last_byte || take_ok);
  assign text.ready = !item_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (text.ready) begin
      item_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      item.text_byte <= text.text_byte;
      item.last_byte <= text.last_byte;
    end
  end

  nsms_stats #(
    .PATTERN_MAX(PATTERN_MAX),
    .TEXT_MAX   (TEXT_MAX)
  ) u_stats (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .cfg    (cfg),
    .take_ok(take_ok),
    .result (result)
  );

endmodule

`default_nettype wire
